// ===== src/gpc_pkg.sv =====
// Shared types and constants of the conserved-to-primitive gas converter.
// Depends on nothing; every other file but gpc_div and gpc_sqrt imports it.
package gpc_pkg;

	localparam int DIMENSIONS_DEF = 3;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH    = 2;

	// Largest positive value of a signed 32-bit fixed-point number.
	localparam logic [30:0] QMAX31 = 31'h7FFF_FFFF;

	// One row of a cell as it arrives on the input stream.
	typedef struct packed {
		logic        [15:0] cell_index;
		logic        [18:0] gamma;
		logic signed [31:0] centroid_x;
		logic signed [31:0] centroid_y;
		logic signed [31:0] centroid_z;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] value;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic signed [31:0] grad_z;
	} row_t;

	// One reconstructed cell, handed from the front to the back.
	typedef struct packed {
		logic        [15:0]      cell_id;
		logic        [18:0]      gamma;
		logic signed [31:0]      density;
		logic        [2:0][31:0] mom;
		logic signed [31:0]      energy;
	} job_t;

	// One result item.
	typedef struct packed {
		logic        [15:0] cell_out;
		logic signed [31:0] density;
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [31:0] velocity_z;
		logic        [30:0] kinetic_energy;
		logic        [30:0] pressure;
		logic        [30:0] temperature;
		logic        [30:0] sound_speed;
		logic        [30:0] mach;
		logic               bad_density;
	} res_t;

endpackage

// ===== src/gpc_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on nothing.
module gpc_div #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   shifted;
	logic [DW:0]   trial;
	logic          fits;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== src/gpc_sqrt.sv =====
// Integer square root, two radicand bits per cycle (digit-by-digit method).
// Depends on nothing.
module gpc_sqrt #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   x,
	output logic           busy,
	output logic [W/2-1:0] root
);

	logic         busy_q;
	logic [W-1:0] x_q;
	logic [W-1:0] res_q;
	logic [W-1:0] bit_q;
	logic [W-1:0] t;

	assign t = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q == W'(1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			res_q <= '0;
			bit_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (x_q >= t) begin
				x_q   <= x_q - t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[W/2-1:0];

endmodule

// ===== src/gpc_fifo.sv =====
// Short register queue of reconstructed cells between front and back.
// Depends on gpc_pkg.
module gpc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gpc_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output gpc_pkg::job_t head
);
	import gpc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = cnt_q == CW'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// ===== src/gpc_front.sv =====
// Front end: takes the rows of a cell, reconstructs each value at the
// centroid with one shared multiplier and pushes the cell to the queue.
// Depends on gpc_pkg.
module gpc_front #(
	parameter int DIMENSIONS = 3,
	parameter int FRAC_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          row_valid,
	output logic          row_ready,
	input  gpc_pkg::row_t row,
	output logic          push,
	output gpc_pkg::job_t job,
	input  logic          full
);
	import gpc_pkg::*;

	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_MUL   = 2'd1;
	localparam logic [1:0] F_STORE = 2'd2;

	logic [1:0]         state_q;
	logic [2:0]         row_q;
	logic [1:0]         step_q;
	logic [15:0]        cell_q;
	logic [18:0]        gamma_q;
	logic [2:0][31:0]   shift_q;
	logic [2:0][31:0]   g_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] dens_q;
	logic [2:0][31:0]   mom_q;
	logic signed [31:0] recon;
	logic [2:0][31:0]   shift_new;
	logic               last_row;

	function automatic logic [31:0] sat_diff(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return d[31:0];
	endfunction

	always_comb begin
		if (acc_q > 64'sh7FFF_FFFF) begin
			recon = 32'sh7FFF_FFFF;
		end else if (acc_q < -64'sh8000_0000) begin
			recon = 32'sh8000_0000;
		end else begin
			recon = acc_q[31:0];
		end
	end

	always_comb begin
		shift_new[0] = sat_diff(row.centroid_x, row.point_x);
		shift_new[1] = sat_diff(row.centroid_y, row.point_y);
		shift_new[2] = (DIMENSIONS > 2) ? sat_diff(row.centroid_z, row.point_z) : 32'd0;
	end

	assign row_ready = state_q == F_IDLE;
	assign last_row  = row_q > 3'(DIMENSIONS);
	assign push      = (state_q == F_STORE) && last_row && !full;

	always_comb begin
		job.cell_id = cell_q;
		job.gamma   = gamma_q;
		job.density = dens_q;
		job.mom     = mom_q;
		job.energy  = recon;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			row_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (row_valid) begin
						step_q  <= '0;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'(DIMENSIONS)) begin
						state_q <= F_STORE;
					end
				end
				F_STORE: begin
					if (row_q == '0) begin
						row_q   <= 3'd1;
						state_q <= F_IDLE;
					end else if (!last_row) begin
						row_q   <= row_q + 1'b1;
						state_q <= F_IDLE;
					end else if (!full) begin
						row_q   <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (row_valid) begin
					cell_q <= row.cell_index;
					acc_q  <= 64'(row.value);
					g_q    <= {row.grad_z, row.grad_y, row.grad_x};
					if (row_q == '0) begin
						gamma_q <= row.gamma;
						shift_q <= shift_new;
					end
				end
			end
			F_MUL: begin
				if (step_q < 2'(DIMENSIONS)) begin
					prod_q <= $signed(g_q[step_q]) * $signed(shift_q[step_q]);
				end
				if (step_q != '0) begin
					acc_q <= acc_q + (prod_q >>> FRAC_BITS);
				end
			end
			F_STORE: begin
				if (row_q == '0) begin
					dens_q <= recon;
				end else if (!last_row) begin
					mom_q[2'(row_q - 3'd1)] <= recon;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== src/gpc_back.sv =====
// Back end: turns one reconstructed cell into primitive variables with a
// shared multiplier, a shared divider and a shared square-root unit.
// Depends on gpc_pkg, gpc_div and gpc_sqrt.
module gpc_back #(
	parameter int DIMENSIONS = 3,
	parameter int FRAC_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  gpc_pkg::job_t q_head,
	output logic          q_pop,
	output gpc_pkg::res_t res,
	output logic          res_valid,
	input  logic          res_ready
);
	import gpc_pkg::*;

	localparam logic [4:0] B_IDLE  = 5'd0;
	localparam logic [4:0] B_VGO   = 5'd1;
	localparam logic [4:0] B_VWAIT = 5'd2;
	localparam logic [4:0] B_VSQ   = 5'd3;
	localparam logic [4:0] B_VACC  = 5'd4;
	localparam logic [4:0] B_KLO   = 5'd5;
	localparam logic [4:0] B_KHI   = 5'd6;
	localparam logic [4:0] B_KSUM  = 5'd7;
	localparam logic [4:0] B_PMUL  = 5'd8;
	localparam logic [4:0] B_PR    = 5'd9;
	localparam logic [4:0] B_TGO   = 5'd10;
	localparam logic [4:0] B_TWAIT = 5'd11;
	localparam logic [4:0] B_QMUL  = 5'd12;
	localparam logic [4:0] B_QGO   = 5'd13;
	localparam logic [4:0] B_QWAIT = 5'd14;
	localparam logic [4:0] B_SWAIT = 5'd15;
	localparam logic [4:0] B_UGO   = 5'd16;
	localparam logic [4:0] B_UWAIT = 5'd17;
	localparam logic [4:0] B_PWAIT = 5'd18;
	localparam logic [4:0] B_MGO   = 5'd19;
	localparam logic [4:0] B_MWAIT = 5'd20;
	localparam logic [4:0] B_DONE  = 5'd21;

	localparam logic [63:0]        ROOT_LIMIT = 64'd1 << (62 - FRAC_BITS);
	localparam logic signed [33:0] ONE_FX     = 34'sd1 <<< FRAC_BITS;

	logic [4:0]         state_q;
	job_t               job_q;
	logic [1:0]         k_q;
	logic [2:0][31:0]   v_q;
	logic [63:0]        s2_q;
	logic signed [67:0] prod_q;
	logic [63:0]        kacc_q;
	logic [30:0]        ken_q, pr_q, tem_q, sos_q, speed_q, mach_q;
	logic               bad_q;
	res_t               out_q;
	logic               out_valid_q;

	logic               div_start, div_busy;
	logic [63:0]        div_num, div_quo;
	logic [31:0]        div_den;
	logic               sq_start, sq_busy;
	logic [63:0]        sq_x;
	logic [31:0]        sq_root;
	logic signed [33:0] mul_a, mul_b;

	logic [31:0]        m_sel, m_mag, v_sel, v_abs, v_new;
	logic [32:0]        mag33;
	logic [30:0]        quo_cap, ken_new, pr_new;
	logic [95:0]        k_full, k_sh;
	logic signed [33:0] diff, gm1;
	logic signed [67:0] pr_sh;
	logic               load;

	gpc_div #(.NW(64), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quo(div_quo)
	);

	gpc_sqrt #(.W(64)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .x(sq_x),
		.busy(sq_busy), .root(sq_root)
	);

	always_comb begin
		m_sel   = job_q.mom[k_q];
		m_mag   = m_sel[31] ? 32'd0 - m_sel : m_sel;
		v_sel   = v_q[k_q];
		v_abs   = v_sel[31] ? 32'd0 - v_sel : v_sel;
		quo_cap = (div_quo > 64'(QMAX31)) ? QMAX31 : div_quo[30:0];
		mag33   = (div_quo > 64'h8000_0000) ? 33'h0_8000_0000 : div_quo[32:0];
		if (m_sel[31]) begin
			v_new = 32'(33'd0 - mag33);
		end else begin
			v_new = (div_quo > 64'(QMAX31)) ? 32'h7FFF_FFFF : div_quo[31:0];
		end
		k_full  = {32'd0, kacc_q} + {prod_q[63:0], 32'd0};
		k_sh    = k_full >> (FRAC_BITS + 1);
		ken_new = (k_sh > 96'(QMAX31)) ? QMAX31 : k_sh[30:0];
		diff    = {{2{job_q.energy[31]}}, job_q.energy} - {3'd0, ken_q};
		gm1     = $signed({15'd0, job_q.gamma}) - ONE_FX;
		pr_sh   = prod_q >>> FRAC_BITS;
		if (pr_sh < 0) begin
			pr_new = '0;
		end else if (pr_sh > 68'sh7FFF_FFFF) begin
			pr_new = QMAX31;
		end else begin
			pr_new = pr_sh[30:0];
		end
	end

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = job_q.density;
		sq_start  = 1'b0;
		sq_x      = '0;
		case (state_q)
			B_VSQ: begin
				mul_a = {2'b0, v_abs};
				mul_b = {2'b0, v_abs};
			end
			B_KLO: begin
				mul_a = {2'b0, job_q.density};
				mul_b = {2'b0, s2_q[31:0]};
			end
			B_KHI: begin
				mul_a = {2'b0, job_q.density};
				mul_b = {2'b0, s2_q[63:32]};
			end
			B_PMUL: begin
				mul_a = diff;
				mul_b = gm1;
			end
			B_QMUL: begin
				mul_a = {15'd0, job_q.gamma};
				mul_b = {3'd0, pr_q};
			end
			B_VGO: begin
				div_start = 1'b1;
				div_num   = 64'(m_mag) << FRAC_BITS;
			end
			B_TGO: begin
				div_start = 1'b1;
				div_num   = 64'(pr_q) << FRAC_BITS;
			end
			B_QGO: begin
				div_start = 1'b1;
				div_num   = prod_q[63:0];
			end
			B_UGO: begin
				div_start = 1'b1;
				div_num   = 64'(ken_q) << (FRAC_BITS + 1);
			end
			B_QWAIT, B_UWAIT: begin
				if (!div_busy && div_quo < ROOT_LIMIT) begin
					sq_start = 1'b1;
					sq_x     = div_quo << FRAC_BITS;
				end
			end
			B_MGO: begin
				div_start = sos_q != '0;
				div_num   = 64'(speed_q) << FRAC_BITS;
				div_den   = {1'b0, sos_q};
			end
			B_MWAIT: begin
				div_den = {1'b0, sos_q};
			end
			default: ;
		endcase
	end

	assign q_pop = (state_q == B_IDLE) && !q_empty;
	assign load  = (state_q == B_DONE) && (!out_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= (q_head.density <= 0) ? B_DONE : B_VGO;
					end
				end
				B_VGO:   state_q <= B_VWAIT;
				B_VWAIT: if (!div_busy) state_q <= B_VSQ;
				B_VSQ:   state_q <= B_VACC;
				B_VACC:  state_q <= (k_q == 2'(DIMENSIONS - 1)) ? B_KLO : B_VGO;
				B_KLO:   state_q <= B_KHI;
				B_KHI:   state_q <= B_KSUM;
				B_KSUM:  state_q <= B_PMUL;
				B_PMUL:  state_q <= B_PR;
				B_PR:    state_q <= B_TGO;
				B_TGO:   state_q <= B_TWAIT;
				B_TWAIT: if (!div_busy) state_q <= B_QMUL;
				B_QMUL:  state_q <= B_QGO;
				B_QGO:   state_q <= B_QWAIT;
				B_QWAIT: begin
					if (!div_busy) begin
						state_q <= (div_quo < ROOT_LIMIT) ? B_SWAIT : B_UGO;
					end
				end
				B_SWAIT: if (!sq_busy) state_q <= B_UGO;
				B_UGO:   state_q <= B_UWAIT;
				B_UWAIT: begin
					if (!div_busy) begin
						state_q <= (div_quo < ROOT_LIMIT) ? B_PWAIT : B_MGO;
					end
				end
				B_PWAIT: if (!sq_busy) state_q <= B_MGO;
				B_MGO:   state_q <= (sos_q == '0) ? B_DONE : B_MWAIT;
				B_MWAIT: if (!div_busy) state_q <= B_DONE;
				B_DONE:  if (load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (load) begin
			out_q.cell_out       <= job_q.cell_id;
			out_q.density        <= job_q.density;
			out_q.velocity_x     <= v_q[0];
			out_q.velocity_y     <= v_q[1];
			out_q.velocity_z     <= v_q[2];
			out_q.kinetic_energy <= ken_q;
			out_q.pressure       <= pr_q;
			out_q.temperature    <= tem_q;
			out_q.sound_speed    <= sos_q;
			out_q.mach           <= mach_q;
			out_q.bad_density    <= bad_q;
		end
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					job_q <= q_head;
					k_q   <= '0;
					s2_q  <= '0;
					bad_q <= q_head.density <= 0;
					// On a flagged cell velocities take the sign of their momentum at
					// full scale; otherwise they start at zero.
					for (int k = 0; k < 3; k++) begin
						if (q_head.density <= 0 && k < DIMENSIONS &&
								$signed(q_head.mom[k]) > 0) begin
							v_q[k] <= 32'h7FFF_FFFF;
						end else if (q_head.density <= 0 && k < DIMENSIONS &&
								$signed(q_head.mom[k]) < 0) begin
							v_q[k] <= 32'h8000_0000;
						end else begin
							v_q[k] <= '0;
						end
					end
					if (q_head.density <= 0) begin
						ken_q  <= QMAX31;
						pr_q   <= QMAX31;
						tem_q  <= QMAX31;
						sos_q  <= QMAX31;
						mach_q <= QMAX31;
					end
				end
			end
			B_VWAIT: if (!div_busy) v_q[k_q] <= v_new;
			B_VACC: begin
				s2_q <= s2_q + (prod_q[63:0] >> FRAC_BITS);
				k_q  <= k_q + 1'b1;
			end
			B_KHI:   kacc_q <= prod_q[63:0];
			B_KSUM:  ken_q <= ken_new;
			B_PR:    pr_q <= pr_new;
			B_TWAIT: if (!div_busy) tem_q <= quo_cap;
			B_QWAIT: if (!div_busy && div_quo >= ROOT_LIMIT) sos_q <= QMAX31;
			B_SWAIT: if (!sq_busy) sos_q <= sq_root[30:0];
			B_UWAIT: if (!div_busy && div_quo >= ROOT_LIMIT) speed_q <= QMAX31;
			B_PWAIT: if (!sq_busy) speed_q <= sq_root[30:0];
			B_MGO:   if (sos_q == '0) mach_q <= '0;
			B_MWAIT: if (!div_busy) mach_q <= quo_cap;
			default: ;
		endcase
	end

	assign res       = out_q;
	assign res_valid = out_valid_q;

endmodule

// ===== src/gas_primitive_from_conserved_unit.sv =====
// A row passes the front's idle, multiply and store states (one product per axis on a shared
// multiplier), and a cell is DIMENSIONS+2 rows.
// Throughput is set by the back, which at three dimensions runs up to seven divisions on one
// radix-2 divider, up to two square roots and a few multiply steps per cell.
// A two-entry queue lets the front take the next cell while the back still works.
// Reset (arst_n low, asynchronous) empties the queue, restarts the row count and drops m_tvalid.
module gas_primitive_from_conserved_unit #(
	parameter int DIMENSIONS = gpc_pkg::DIMENSIONS_DEF,
	parameter int FRAC_BITS  = gpc_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cell_index, gamma, centroid_x, centroid_y, centroid_z, point_x, point_y,
	// point_z, value, grad_x, grad_y, grad_z, then five zero bits
	input  logic [359:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cell_out, density, velocity_x, velocity_y, velocity_z, kinetic_energy,
	// pressure, temperature, sound_speed, mach, then five zero bits
	output logic [303:0] m_tdata,
	// bad_density
	output logic         m_tuser
);
	import gpc_pkg::*;

	row_t row;
	job_t push_job, head_job;
	res_t res;
	logic push, full, pop, empty;

	// Unpack one input transfer into the row fields.
	always_comb begin
		row.cell_index = s_tdata[15:0];
		row.gamma      = s_tdata[34:16];
		row.centroid_x = s_tdata[66:35];
		row.centroid_y = s_tdata[98:67];
		row.centroid_z = s_tdata[130:99];
		row.point_x    = s_tdata[162:131];
		row.point_y    = s_tdata[194:163];
		row.point_z    = s_tdata[226:195];
		row.value      = s_tdata[258:227];
		row.grad_x     = s_tdata[290:259];
		row.grad_y     = s_tdata[322:291];
		row.grad_z     = s_tdata[354:323];
	end

	// The front accepts rows and reconstructs them at the centroid.
	gpc_front #(.DIMENSIONS(DIMENSIONS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .row_valid(s_tvalid), .row_ready(s_tready),
		.row(row), .push(push), .job(push_job), .full(full)
	);

	// Completed cells wait here so that each side can stall on its own.
	gpc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(push_job), .full(full),
		.pop(pop), .empty(empty), .head(head_job)
	);

	// The back derives the primitive variables and holds the output register.
	gpc_back #(.DIMENSIONS(DIMENSIONS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(empty), .q_head(head_job), .q_pop(pop),
		.res(res), .res_valid(m_tvalid), .res_ready(m_tready)
	);

	assign m_tdata = {5'd0, res.mach, res.sound_speed, res.temperature, res.pressure,
		res.kinetic_energy, res.velocity_z, res.velocity_y, res.velocity_x,
		res.density, res.cell_out};
	assign m_tuser = res.bad_density;

	// A flagged cell carries saturated derived values.
	a_bad_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.bad_density) |-> (res.kinetic_energy == QMAX31 &&
		res.mach == QMAX31)) else $error("flagged cell without saturated outputs");

	// An unflagged cell always has positive density.
	a_good_dens: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res.bad_density) |-> (res.density > 0))
		else $error("unflagged cell with density not positive");

	// Zero sound speed forces a zero Mach number.
	a_mach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.sound_speed == '0) |-> (res.mach == '0))
		else $error("nonzero mach with zero sound speed");

endmodule

// ===== tb/sv/tb_gas_primitive_from_conserved_unit.sv =====
// Self-checking testbench of the conserved-to-primitive gas converter.
// Depends on gpc_pkg and gas_primitive_from_conserved_unit; streams whole cells of rows
// and checks every result against a fixed-point predictor kept in this file.
module tb_gas_primitive_from_conserved_unit;
	import gpc_pkg::*;

	localparam int  DIM        = 3;
	localparam int  FB         = 16;
	localparam int  ROWS       = DIM + 2;
	localparam int  NUM_CELLS  = 90;          // 450 random rows; 475 with the directed cells
	localparam int  PAUSE_CELL = 50;          // the sender drains the block before this cell
	localparam int  HOLD_AT    = 20;          // the receiver stalls after this many results
	localparam int  HOLD_LEN   = 3000;
	localparam int  IDLE_LIMIT = 20000;
	localparam longint QMAX    = 64'h7FFF_FFFF;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [359:0] s_tdata  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [303:0] m_tdata;
	logic         m_tuser;

	gas_primitive_from_conserved_unit #(.DIMENSIONS(DIM), .FRAC_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	// Rows waiting to be offered, and results the predictor says must come out.
	logic [359:0] pending_rows[$];
	res_t         cell_results[$];
	int           mismatches  = 0;
	int           rows_sent   = 0;
	int           results_got = 0;

	// Predictor state: what the block latches across the rows of one cell.
	int unsigned  row_phase;
	longint       gamma_q;
	longint       shift_q[3];
	longint       dens_q;
	longint       mom_q[3];

	function automatic longint sat32(longint x);
		if (x > QMAX) return QMAX;
		if (x < -QMAX - 1) return -QMAX - 1;
		return x;
	endfunction

	function automatic longint unsigned cap31(longint unsigned x);
		return (x > QMAX) ? QMAX : x;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Full-scale value with the sign of a momentum, zero for zero momentum.
	function automatic logic [31:0] sign_sat(longint m);
		return (m > 0) ? 32'h7FFF_FFFF : ((m < 0) ? 32'h8000_0000 : 32'h0);
	endfunction

	// Value moved from the solution point to the centroid along the latched shift.
	function automatic longint at_centroid(row_t r);
		longint acc;
		longint g[3];
		g[0] = longint'(r.grad_x);
		g[1] = longint'(r.grad_y);
		g[2] = longint'(r.grad_z);
		acc = longint'(r.value);
		for (int k = 0; k < DIM; k++) acc += (g[k] * shift_q[k]) >>> FB;
		return sat32(acc);
	endfunction

	function automatic row_t unpack_row(logic [359:0] d);
		row_t r;
		r.cell_index = d[15:0];
		r.gamma      = d[34:16];
		r.centroid_x = d[66:35];
		r.centroid_y = d[98:67];
		r.centroid_z = d[130:99];
		r.point_x    = d[162:131];
		r.point_y    = d[194:163];
		r.point_z    = d[226:195];
		r.value      = d[258:227];
		r.grad_x     = d[290:259];
		r.grad_y     = d[322:291];
		r.grad_z     = d[354:323];
		return r;
	endfunction

	function automatic logic [359:0] pack_row(row_t r);
		return {5'b0, r.grad_z, r.grad_y, r.grad_x, r.value, r.point_z, r.point_y,
			r.point_x, r.centroid_z, r.centroid_y, r.centroid_x, r.gamma, r.cell_index};
	endfunction

	// Advances the predictor by one accepted row; on the energy row it queues the result.
	task automatic convert_row(row_t r);
		longint       e, d, v, diff, pr;
		longint       cen[3], pt[3];
		longint unsigned av, s2, ken, tem, q, sos, u2, speed, mach_v;
		logic [127:0] prod;
		res_t         res;
		if (row_phase == 0) begin
			cen[0] = r.centroid_x; cen[1] = r.centroid_y; cen[2] = r.centroid_z;
			pt[0]  = r.point_x;    pt[1]  = r.point_y;    pt[2]  = r.point_z;
			gamma_q = longint'(r.gamma);
			for (int k = 0; k < 3; k++) shift_q[k] = (k < DIM) ? sat32(cen[k] - pt[k]) : 0;
			dens_q = at_centroid(r);
			row_phase = 1;
		end else if (row_phase <= DIM) begin
			mom_q[row_phase - 1] = at_centroid(r);
			row_phase++;
		end else begin
			row_phase = 0;
			e = at_centroid(r);
			d = dens_q;
			res.cell_out = r.cell_index;
			res.density  = d[31:0];
			if (d <= 0) begin
				// Density that is not positive: velocities take the sign of their
				// momentum and everything derived saturates.
				res.velocity_x = sign_sat(mom_q[0]);
				res.velocity_y = sign_sat(mom_q[1]);
				res.velocity_z = (DIM < 3) ? 32'h0 : sign_sat(mom_q[2]);
				res.kinetic_energy = QMAX31;
				res.pressure       = QMAX31;
				res.temperature    = QMAX31;
				res.sound_speed    = QMAX31;
				res.mach           = QMAX31;
				res.bad_density    = 1'b1;
			end else begin
				s2 = 0;
				for (int k = 0; k < 3; k++) begin
					v = (k < DIM) ? sat32((mom_q[k] <<< FB) / d) : 0;
					if (k == 0) res.velocity_x = v[31:0];
					if (k == 1) res.velocity_y = v[31:0];
					if (k == 2) res.velocity_z = v[31:0];
					av = (v < 0) ? -v : v;
					s2 += (av * av) >> FB;
				end
				prod = 128'(d) * 128'(s2);
				prod = prod >> (FB + 1);
				ken  = (prod > 128'(QMAX)) ? QMAX : prod[63:0];
				diff = e - longint'(ken);
				pr   = (diff * (gamma_q - (64'sd1 <<< FB))) >>> FB;
				if (pr < 0) pr = 0;
				if (pr > QMAX) pr = QMAX;
				tem = cap31((longint'(pr) << FB) / d);
				q   = (gamma_q * pr) / d;
				sos = (q >= (64'd1 << (62 - FB))) ? QMAX : cap31(int_sqrt(q << FB));
				u2  = (ken << (FB + 1)) / d;
				speed = (u2 >= (64'd1 << (62 - FB))) ? QMAX : cap31(int_sqrt(u2 << FB));
				// A zero sound speed turns the guarded ratio into zero.
				mach_v = (sos == 0) ? 0 : cap31((speed << FB) / sos);
				res.kinetic_energy = ken[30:0];
				res.pressure       = pr[30:0];
				res.temperature    = tem[30:0];
				res.sound_speed    = sos[30:0];
				res.mach           = mach_v[30:0];
				res.bad_density    = 1'b0;
			end
			cell_results.push_back(res);
		end
	endtask

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch on result %0d, %s: got %h, want %h", results_got, field, got, want);
	endtask

	task automatic compare_result(logic [303:0] d, logic bad);
		res_t w;
		if (cell_results.size() == 0) begin
			mismatches++;
			$display("result %0d arrived with none outstanding", results_got);
			return;
		end
		w = cell_results.pop_front();
		if (d[15:0]    !== w.cell_out)       report("cell_out", d[15:0], w.cell_out);
		if (d[47:16]   !== w.density)        report("density", d[47:16], w.density);
		if (d[79:48]   !== w.velocity_x)     report("velocity_x", d[79:48], w.velocity_x);
		if (d[111:80]  !== w.velocity_y)     report("velocity_y", d[111:80], w.velocity_y);
		if (d[143:112] !== w.velocity_z)     report("velocity_z", d[143:112], w.velocity_z);
		if (d[174:144] !== w.kinetic_energy) report("kinetic_energy", d[174:144],
			w.kinetic_energy);
		if (d[205:175] !== w.pressure)       report("pressure", d[205:175], w.pressure);
		if (d[236:206] !== w.temperature)    report("temperature", d[236:206], w.temperature);
		if (d[267:237] !== w.sound_speed)    report("sound_speed", d[267:237], w.sound_speed);
		if (d[298:268] !== w.mach)           report("mach", d[298:268], w.mach);
		if (bad !== w.bad_density)           report("bad_density", bad, w.bad_density);
	endtask

	// Mostly short gaps, now and then a long one; the first rows of each hundred go
	// back to back so the block also sees full-rate stretches.
	function automatic int pick_gap(int n);
		int p;
		if ((n % 100) < 30) return 0;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(80, 20);
	endfunction

	function automatic logic [31:0] small_signed(int unsigned mag);
		return 32'($signed($urandom_range(2 * mag)) - $signed(mag));
	endfunction

	// Builds one cell of rows. The kind picks realistic, fully random or
	// small density content of either sign; ignored fields still carry random bits.
	task automatic queue_cell(int kind);
		row_t r;
		logic [15:0] cell_id;
		cell_id = 16'($urandom);
		for (int i = 0; i < ROWS; i++) begin
			r = unpack_row(360'({$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
			if (i == ROWS - 1) r.cell_index = cell_id;
			if (kind != 1) begin
				r.gamma = ($urandom_range(9) < 8) ? 19'($urandom_range(262144, 65536)) :
					19'($urandom);
				if (i == 0) begin
					r.centroid_x = small_signed(1 << 18); r.point_x = small_signed(1 << 18);
					r.centroid_y = small_signed(1 << 18); r.point_y = small_signed(1 << 18);
					r.centroid_z = small_signed(1 << 18); r.point_z = small_signed(1 << 18);
				end
				r.grad_x = small_signed(1 << 20);
				r.grad_y = small_signed(1 << 20);
				r.grad_z = small_signed(1 << 20);
				if (i == 0)
					r.value = (kind == 2) ? small_signed(1 << 16) : $urandom_range(1 << 22, 1 << 14);
				else if (i < ROWS - 1)
					r.value = small_signed(1 << 22);
				else
					r.value = $urandom_range(1 << 27);
			end
			pending_rows.push_back(pack_row(r));
		end
	endtask

	// Directed cell with every row given by value and one gradient on every axis.
	task automatic queue_plain_cell(logic [15:0] cell_id, logic [18:0] gam,
			logic [31:0] cen, logic [31:0] pt, logic [31:0] vals[ROWS], logic [31:0] grad);
		row_t r;
		for (int i = 0; i < ROWS; i++) begin
			r = '0;
			r.cell_index = cell_id;
			r.gamma = gam;
			r.centroid_x = cen; r.centroid_y = cen; r.centroid_z = cen;
			r.point_x = pt; r.point_y = pt; r.point_z = pt;
			r.value = vals[i];
			r.grad_x = grad; r.grad_y = grad; r.grad_z = grad;
			pending_rows.push_back(pack_row(r));
		end
	endtask

	initial begin
		logic [31:0] v[ROWS];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// All-zero cell: zero density is flagged as bad.
		v = '{default: 32'h0};
		queue_plain_cell(16'h0000, 19'h0, 32'h0, 32'h0, v, 32'h0);
		// Gas at rest: density 1.0, energy 2.5, gamma 1.4.
		v = '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0002_8000};
		queue_plain_cell(16'hFFFF, 19'd91750, 32'h0, 32'h0, v, 32'h0);
		// Negative density with momenta of each sign.
		v = '{32'hFFFF_0000, 32'h0003_0000, 32'hFFFD_0000, 32'h0, 32'h0001_0000};
		queue_plain_cell(16'h1234, 19'd65536, 32'h0, 32'h0, v, 32'h0);
		// Gamma below one: pressure clamps to zero, so sound speed and Mach are zero.
		v = '{32'h0002_0000, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0010_0000};
		queue_plain_cell(16'h00FF, 19'd0, 32'h0, 32'h0, v, 32'h0);
		// Extreme coordinates saturate the shift; largest gamma, full-scale values and gradients.
		v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		queue_plain_cell(16'hABCD, 19'h7FFFF, 32'h7FFF_FFFF, 32'h8000_0000, v, 32'h7FFF_FFFF);

		for (int c = 0; c < NUM_CELLS; c++) begin
			int p;
			p = $urandom_range(99);
			queue_cell(p < 70 ? 0 : (p < 85 ? 1 : 2));
		end

		wait (pending_rows.size() == 0 && !s_tvalid);
		wait (cell_results.size() == 0);
		// The back end may still be busy; give it time to show any stray result.
		repeat (1500) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Sender: offers queued rows, with random gaps and one pause that lets the block drain.
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) convert_row(unpack_row(s_tdata));
			if (s_tvalid && !s_tready) begin
				// The current transfer is still being offered.
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_rows.size() > 0 &&
					!(rows_sent == (PAUSE_CELL + 5) * ROWS && cell_results.size() != 0)) begin
				s_tdata  <= pending_rows.pop_front();
				s_tvalid <= 1'b1;
				rows_sent++;
				send_gap = pick_gap(rows_sent);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls and, once, a long hold-off that backs the block up.
	int  ready_gap = 0;
	int  hold_left = 0;
	bit  held_once = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				compare_result(m_tdata, m_tuser);
				results_got++;
			end
			if (!held_once && results_got == HOLD_AT) begin
				held_once = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				ready_gap = pick_gap(results_got * 7);
			end
		end
	end

	// Watchdog: too long without any transfer on either side ends the run.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== sim.f =====
src/gpc_pkg.sv
src/gpc_div.sv
src/gpc_sqrt.sv
src/gpc_fifo.sv
src/gpc_front.sv
src/gpc_back.sv
src/gas_primitive_from_conserved_unit.sv
tb/sv/tb_gas_primitive_from_conserved_unit.sv
